// ===== rtl/core/rfp_pkg.sv =====
// shared types, codes and constants for the rotary front panel controller
package rfp_pkg;

	localparam int PRESS_COUNT_WIDTH = 8;
	localparam int THRESH_W = 8;
	localparam int CMP_W = (PRESS_COUNT_WIDTH > THRESH_W) ? PRESS_COUNT_WIDTH : THRESH_W;
	localparam logic [PRESS_COUNT_WIDTH-1:0] PRESS_MAX = '1;

	localparam int HOUR_W = 5;
	localparam int MIN_W = 6;
	localparam int STEP_W = 5;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 8;

	localparam logic [MIN_W:0] MIN_PER_HOUR = 7'd60;
	localparam logic [HOUR_W:0] HOUR_PER_DAY = 6'd24;
	localparam logic [HOUR_W-1:0] LAST_HOUR = 5'd23;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_START_HOUR   = 3'd0,
		CFG_START_MINUTE = 3'd1,
		CFG_STEP_MINUTES = 3'd2,
		CFG_SHORT_ABOVE  = 3'd3,
		CFG_SHORT_BELOW  = 3'd4,
		CFG_LONG_ABOVE   = 3'd5
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ROT_NONE = 2'd0,
		ROT_NEXT = 2'd1,
		ROT_PREV = 2'd2,
		ROT_TIME = 2'd3
	} rot_ev_t;

	typedef enum logic [1:0] {
		BTN_NONE  = 2'd0,
		BTN_STOP  = 2'd1,
		BTN_PLAY  = 2'd2,
		BTN_ALARM = 2'd3
	} btn_ev_t;

	typedef struct packed {
		logic [STEP_W-1:0]   step_minutes;
		logic [THRESH_W-1:0] short_above;
		logic [THRESH_W-1:0] short_below;
		logic [THRESH_W-1:0] long_above;
	} cfg_t;

	typedef struct packed {
		logic enc_a;
		logic enc_b;
		logic button_level;
		logic slow_tick;
		logic radio_playing;
	} sample_t;

	typedef struct packed {
		logic                         latched_b;
		logic                         tracked_b;
		logic                         a_low_seen;
		logic [PRESS_COUNT_WIDTH-1:0] press_ticks;
		logic [HOUR_W-1:0]            alarm_hour;
		logic [MIN_W-1:0]             alarm_minute;
		logic                         power_state;
		logic                         alarm_on;
	} panel_state_t;

	typedef struct packed {
		rot_ev_t           rotary_event;
		btn_ev_t           button_event;
		logic [HOUR_W-1:0] alarm_hour;
		logic [MIN_W-1:0]  alarm_minute;
		logic              power_on;
		logic              alarm_enabled;
	} result_t;

endpackage

// ===== rtl/core/rfp_step.sv =====
// next-state and result logic for one pin sample: detent decode, alarm time, button timing
module rfp_step (
	input  rfp_pkg::sample_t     sample,
	input  rfp_pkg::cfg_t        cfg,
	input  rfp_pkg::panel_state_t cur,
	output rfp_pkg::panel_state_t nxt,
	output rfp_pkg::result_t     res
);

	logic [rfp_pkg::MIN_W:0]    min_up;
	logic [rfp_pkg::MIN_W:0]    min_wrap_down;
	logic [rfp_pkg::HOUR_W:0]   hour_inc;
	logic [rfp_pkg::MIN_W-1:0]  up_minute;
	logic [rfp_pkg::HOUR_W-1:0] up_hour;
	logic [rfp_pkg::MIN_W-1:0]  dn_minute;
	logic [rfp_pkg::HOUR_W-1:0] dn_hour;
	logic                       dir_up;
	logic                       dir_dn;
	logic                       detent;
	logic [rfp_pkg::CMP_W-1:0]  ticks_x;
	logic                       short_hit;
	logic                       long_hit;
	rfp_pkg::rot_ev_t           rot_ev;
	rfp_pkg::btn_ev_t           btn_ev;

	// time step arithmetic
	always_comb begin
		min_up = {1'b0, cur.alarm_minute} + {2'b00, cfg.step_minutes};
		hour_inc = {1'b0, cur.alarm_hour} + 6'd1;
		min_wrap_down = {1'b0, cur.alarm_minute} + rfp_pkg::MIN_PER_HOUR
			- {2'b00, cfg.step_minutes};
		if (min_up >= rfp_pkg::MIN_PER_HOUR) begin
			up_minute = rfp_pkg::MIN_W'(min_up - rfp_pkg::MIN_PER_HOUR);
			if (hour_inc >= rfp_pkg::HOUR_PER_DAY) begin
				up_hour = '0;
			end else begin
				up_hour = hour_inc[rfp_pkg::HOUR_W-1:0];
			end
		end else begin
			up_minute = min_up[rfp_pkg::MIN_W-1:0];
			up_hour = cur.alarm_hour;
		end
		if ({1'b0, cur.alarm_minute} < {2'b00, cfg.step_minutes}) begin
			dn_minute = min_wrap_down[rfp_pkg::MIN_W-1:0];
			if (cur.alarm_hour == '0) begin
				dn_hour = rfp_pkg::LAST_HOUR;
			end else begin
				dn_hour = cur.alarm_hour - 5'd1;
			end
		end else begin
			dn_minute = cur.alarm_minute - {1'b0, cfg.step_minutes};
			dn_hour = cur.alarm_hour;
		end
	end

	assign detent = sample.enc_a && cur.a_low_seen;
	assign dir_up = detent && !cur.latched_b && cur.tracked_b;
	assign dir_dn = detent && cur.latched_b && !cur.tracked_b;

	assign ticks_x = rfp_pkg::CMP_W'(cur.press_ticks);
	assign short_hit = sample.button_level
		&& (ticks_x > rfp_pkg::CMP_W'(cfg.short_above))
		&& (ticks_x < rfp_pkg::CMP_W'(cfg.short_below));
	assign long_hit = sample.button_level && (ticks_x > rfp_pkg::CMP_W'(cfg.long_above));

	always_comb begin
		nxt = cur;
		rot_ev = rfp_pkg::ROT_NONE;
		btn_ev = rfp_pkg::BTN_NONE;

		// encoder: latch b while a high, track b while a low
		if (sample.enc_a) begin
			nxt.a_low_seen = 1'b0;
			nxt.latched_b = sample.enc_b;
			if (dir_up) begin
				if (sample.radio_playing) begin
					rot_ev = rfp_pkg::ROT_NEXT;
				end else begin
					rot_ev = rfp_pkg::ROT_TIME;
					nxt.alarm_minute = up_minute;
					nxt.alarm_hour = up_hour;
				end
			end else if (dir_dn) begin
				if (sample.radio_playing) begin
					rot_ev = rfp_pkg::ROT_PREV;
				end else begin
					rot_ev = rfp_pkg::ROT_TIME;
					nxt.alarm_minute = dn_minute;
					nxt.alarm_hour = dn_hour;
				end
			end
		end else begin
			nxt.tracked_b = sample.enc_b;
			nxt.a_low_seen = 1'b1;
		end

		// button: count ticks while held, classify on release
		if (!sample.button_level) begin
			if (sample.slow_tick && cur.press_ticks != rfp_pkg::PRESS_MAX) begin
				nxt.press_ticks = cur.press_ticks + 1'b1;
			end
		end else begin
			nxt.press_ticks = '0;
			if (short_hit) begin
				if (sample.radio_playing) begin
					btn_ev = rfp_pkg::BTN_STOP;
					nxt.power_state = 1'b0;
				end else begin
					btn_ev = rfp_pkg::BTN_PLAY;
					nxt.power_state = 1'b1;
				end
			end
			if (long_hit) begin
				btn_ev = rfp_pkg::BTN_ALARM;
				nxt.alarm_on = !cur.alarm_on;
			end
		end
	end

	always_comb begin
		res.rotary_event = rot_ev;
		res.button_event = btn_ev;
		res.alarm_hour = nxt.alarm_hour;
		res.alarm_minute = nxt.alarm_minute;
		res.power_on = nxt.power_state;
		res.alarm_enabled = nxt.alarm_on;
	end

endmodule

// ===== rtl/core/rotary_front_panel_controller_top.sv =====
// top level of the rotary front panel controller: sample register, state, result register
// Usage:
//   in channel: one word per pin sample (enc_a, enc_b, button_level, slow_tick,
//   radio_playing), accepted when in_valid and in_ready are high.
//   out channel: one result word per sample (rotary_event, button_event, alarm
//   time, power_on, alarm_enabled), taken when out_valid and out_ready are high.
//   cfg channel: cfg_index selects a register, cfg_data is written when cfg_valid
//   and cfg_ready are high; cfg_ready is always high. Write only while idle.
//   Writing the start hour or start minute also loads the kept alarm time.
// Flow: a sample lands in the input register, and its result is registered in the
// output register, which raises out_valid.
// Throughput: one sample per cycle while results are taken, as the panel state is
// updated combinationally between the input register and the output register.
// Reset: registers return to defaults, alarm time 00:00, power on, alarm off,
// encoder and press counter cleared; both channels hold no word.
// Stall: a held result keeps the output register; one more sample waits in the
// input register, and in_ready drops only when both are full.
module rotary_front_panel_controller_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              enc_a,
	input  logic                              enc_b,
	input  logic                              button_level,
	input  logic                              slow_tick,
	input  logic                              radio_playing,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [1:0]                        rotary_event,
	output logic [1:0]                        button_event,
	output logic [rfp_pkg::HOUR_W-1:0]        alarm_hour_out,
	output logic [rfp_pkg::MIN_W-1:0]         alarm_minute_out,
	output logic                              power_on,
	output logic                              alarm_enabled,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [rfp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rfp_pkg::CFG_DATA_W-1:0]    cfg_data
);

	rfp_pkg::cfg_t         cfg_q;
	rfp_pkg::panel_state_t state_q;
	rfp_pkg::panel_state_t state_nxt;
	rfp_pkg::sample_t      sample_s1;
	logic                  valid_s1;
	rfp_pkg::result_t      res_nxt;
	rfp_pkg::result_t      res_q;
	logic                  out_valid_q;
	logic                  advance;
	logic                  cfg_wr;

	assign cfg_ready = 1'b1;
	assign cfg_wr = cfg_valid && cfg_ready;

	assign advance = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	rfp_step u_step (
		.sample (sample_s1),
		.cfg    (cfg_q),
		.cur    (state_q),
		.nxt    (state_nxt),
		.res    (res_nxt)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_minutes <= 5'd5;
			cfg_q.short_above <= 8'd5;
			cfg_q.short_below <= 8'd12;
			cfg_q.long_above <= 8'd25;
		end else if (cfg_wr) begin
			case (cfg_index)
				rfp_pkg::CFG_STEP_MINUTES: cfg_q.step_minutes <= cfg_data[rfp_pkg::STEP_W-1:0];
				rfp_pkg::CFG_SHORT_ABOVE:  cfg_q.short_above <= cfg_data;
				rfp_pkg::CFG_SHORT_BELOW:  cfg_q.short_below <= cfg_data;
				rfp_pkg::CFG_LONG_ABOVE:   cfg_q.long_above <= cfg_data;
				default: ;
			endcase
		end
	end

	// panel state; a start time write loads the kept alarm time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.latched_b <= 1'b0;
			state_q.tracked_b <= 1'b0;
			state_q.a_low_seen <= 1'b0;
			state_q.press_ticks <= '0;
			state_q.alarm_hour <= '0;
			state_q.alarm_minute <= '0;
			state_q.power_state <= 1'b1;
			state_q.alarm_on <= 1'b0;
		end else if (cfg_wr) begin
			case (cfg_index)
				rfp_pkg::CFG_START_HOUR:
					state_q.alarm_hour <= cfg_data[rfp_pkg::HOUR_W-1:0];
				rfp_pkg::CFG_START_MINUTE:
					state_q.alarm_minute <= cfg_data[rfp_pkg::MIN_W-1:0];
				default: ;
			endcase
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sample_s1.enc_a <= enc_a;
			sample_s1.enc_b <= enc_b;
			sample_s1.button_level <= button_level;
			sample_s1.slow_tick <= slow_tick;
			sample_s1.radio_playing <= radio_playing;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign rotary_event = res_q.rotary_event;
	assign button_event = res_q.button_event;
	assign alarm_hour_out = res_q.alarm_hour;
	assign alarm_minute_out = res_q.alarm_minute;
	assign power_on = res_q.power_on;
	assign alarm_enabled = res_q.alarm_enabled;

endmodule

// ===== dv/tb.sv =====
// rotary front panel controller testbench: directed and random pin samples checked against a model
module tb;

	localparam int QUIET_LIMIT = 1000;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic enc_a = 1'b0;
	logic enc_b = 1'b0;
	logic button_level = 1'b1;
	logic slow_tick = 1'b0;
	logic radio_playing = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] rotary_event;
	logic [1:0] button_event;
	logic [rfp_pkg::HOUR_W-1:0] alarm_hour_out;
	logic [rfp_pkg::MIN_W-1:0] alarm_minute_out;
	logic power_on;
	logic alarm_enabled;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [rfp_pkg::CFG_IDX_W-1:0] cfg_index = rfp_pkg::CFG_START_HOUR;
	logic [rfp_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	rotary_front_panel_controller_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.enc_a(enc_a),
		.enc_b(enc_b),
		.button_level(button_level),
		.slow_tick(slow_tick),
		.radio_playing(radio_playing),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.rotary_event(rotary_event),
		.button_event(button_event),
		.alarm_hour_out(alarm_hour_out),
		.alarm_minute_out(alarm_minute_out),
		.power_on(power_on),
		.alarm_enabled(alarm_enabled),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// panel model: registers and state as after reset
	int cfg_step = 5;
	int cfg_short_above = 5;
	int cfg_short_below = 12;
	int cfg_long_above = 25;
	bit st_latched_b = 1'b0;
	bit st_tracked_b = 1'b0;
	bit st_a_low = 1'b0;
	int st_ticks = 0;
	int st_hour = 0;
	int st_minute = 0;
	bit st_power = 1'b1;
	bit st_alarm = 1'b0;

	rfp_pkg::sample_t pin_samples[$];
	rfp_pkg::result_t due_results[$];
	logic [1:0] enc_plan[$];	// {enc_a, enc_b}
	logic [1:0] btn_plan[$];	// {button_level, slow_tick}
	bit gen_playing = 1'b0;

	int n_err = 0;
	int n_sent = 0;
	int n_got = 0;
	bit in_taken = 1'b0;
	int stall_left = 0;
	bit stalled_once = 1'b0;
	int quiet_cycles = 0;
	rfp_pkg::sample_t drv_s;
	rfp_pkg::result_t want_r;
	rfp_pkg::result_t next_r;

	task automatic advance_panel(input rfp_pkg::sample_t s, output rfp_pkg::result_t r);
		rfp_pkg::rot_ev_t rot;
		rfp_pkg::btn_ev_t btn;
		int m;
		rot = rfp_pkg::ROT_NONE;
		btn = rfp_pkg::BTN_NONE;
		if (s.enc_a) begin
			if (st_a_low) begin
				st_a_low = 1'b0;
				if (!st_latched_b && st_tracked_b) begin
					if (s.radio_playing) begin
						rot = rfp_pkg::ROT_NEXT;
					end else begin
						m = st_minute + cfg_step;
						if (m >= 60) begin
							m -= 60;
							st_hour++;
							if (st_hour >= 24)
								st_hour = 0;
						end
						st_minute = m & 63;
						rot = rfp_pkg::ROT_TIME;
					end
				end else if (st_latched_b && !st_tracked_b) begin
					if (s.radio_playing) begin
						rot = rfp_pkg::ROT_PREV;
					end else begin
						if (st_minute < cfg_step) begin
							st_minute = (st_minute + 60 - cfg_step) & 63;
							st_hour = (st_hour == 0) ? 23 : st_hour - 1;
						end else begin
							st_minute -= cfg_step;
						end
						rot = rfp_pkg::ROT_TIME;
					end
				end
			end
			st_latched_b = s.enc_b;
		end else begin
			st_tracked_b = s.enc_b;
			st_a_low = 1'b1;
		end

		if (!s.button_level) begin
			if (s.slow_tick && st_ticks < int'(rfp_pkg::PRESS_MAX))
				st_ticks++;
		end else begin
			if (st_ticks > cfg_short_above && st_ticks < cfg_short_below) begin
				btn = s.radio_playing ? rfp_pkg::BTN_STOP : rfp_pkg::BTN_PLAY;
				st_power = !s.radio_playing;
			end
			if (st_ticks > cfg_long_above) begin
				st_alarm = !st_alarm;
				btn = rfp_pkg::BTN_ALARM;
			end
			st_ticks = 0;
		end

		r.rotary_event = rot;
		r.button_event = btn;
		r.alarm_hour = rfp_pkg::HOUR_W'(st_hour);
		r.alarm_minute = rfp_pkg::MIN_W'(st_minute);
		r.power_on = st_power;
		r.alarm_enabled = st_alarm;
	endtask

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			n_err++;
		end
	endfunction

	// acceptance, prediction and result checks
	always @(posedge clk) begin
		in_taken = in_valid && in_ready;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (rfp_pkg::cfg_idx_t'(cfg_index))
					rfp_pkg::CFG_START_HOUR: begin
						st_hour = cfg_data & 8'h1f;
					end
					rfp_pkg::CFG_START_MINUTE: begin
						st_minute = cfg_data & 8'h3f;
					end
					rfp_pkg::CFG_STEP_MINUTES: cfg_step = cfg_data & 8'h1f;
					rfp_pkg::CFG_SHORT_ABOVE: cfg_short_above = cfg_data;
					rfp_pkg::CFG_SHORT_BELOW: cfg_short_below = cfg_data;
					rfp_pkg::CFG_LONG_ABOVE: cfg_long_above = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				n_got++;
				if (due_results.size() == 0) begin
					$display("%0t: unexpected result word, expected none, actual %0d/%0d",
						$time, rotary_event, button_event);
					n_err++;
				end else begin
					want_r = due_results.pop_front();
					check_field("rotary_event", want_r.rotary_event, rotary_event);
					check_field("button_event", want_r.button_event, button_event);
					check_field("alarm_hour_out", want_r.alarm_hour, alarm_hour_out);
					check_field("alarm_minute_out", want_r.alarm_minute, alarm_minute_out);
					check_field("power_on", want_r.power_on, power_on);
					check_field("alarm_enabled", want_r.alarm_enabled, alarm_enabled);
				end
			end
			if (in_valid && in_ready) begin
				advance_panel({enc_a, enc_b, button_level, slow_tick, radio_playing}, next_r);
				due_results.push_back(next_r);
			end
		end
	end

	// sample driver
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (pin_samples.size() == 0 ||
					(!(n_sent >= 400 && n_sent < 520) && $urandom_range(99) < 28)) begin
				in_valid <= 1'b0;
			end else begin
				drv_s = pin_samples.pop_front();
				in_valid <= 1'b1;
				enc_a <= drv_s.enc_a;
				enc_b <= drv_s.enc_b;
				button_level <= drv_s.button_level;
				slow_tick <= drv_s.slow_tick;
				radio_playing <= drv_s.radio_playing;
				n_sent++;
			end
		end
	end

	// result acceptor, with one long hold-off to back up the block
	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else if (!stalled_once && n_got >= 120) begin
			stalled_once = 1'b1;
			stall_left = 49;
			out_ready <= 1'b0;
		end else begin
			out_ready <= (n_got >= 400 && n_got < 520) || $urandom_range(99) >= 28;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic rfp_pkg::sample_t pin(bit a, bit b, bit btn, bit tick, bit play);
		rfp_pkg::sample_t s;
		s.enc_a = a;
		s.enc_b = b;
		s.button_level = btn;
		s.slow_tick = tick;
		s.radio_playing = play;
		return s;
	endfunction

	// press length aimed at the windows of the current thresholds
	function automatic int pick_ticks();
		int roll;
		roll = $urandom_range(99);
		if (roll < 20)
			return $urandom_range(2);
		if (roll < 55 && cfg_short_below - cfg_short_above >= 2 && cfg_short_above < 40)
			return $urandom_range(cfg_short_below - 1 > 40 ? 40 : cfg_short_below - 1,
				cfg_short_above + 1);
		if (roll < 85 && cfg_long_above < 40)
			return cfg_long_above + 1 + $urandom_range(2);
		return $urandom_range(12);
	endfunction

	task automatic plan_encoder();
		bit b_hi;
		bit b_lo;
		int roll;
		roll = $urandom_range(99);
		if (roll < 15) begin
			repeat ($urandom_range(4, 1)) enc_plan.push_back(2'($urandom));
		end else begin
			b_hi = 1'($urandom);
			b_lo = (roll < 25) ? b_hi : !b_hi;
			repeat ($urandom_range(3, 1)) enc_plan.push_back({1'b1, b_hi});
			// bounce on B while A is low, last level wins
			repeat ($urandom_range(2)) enc_plan.push_back({1'b0, 1'($urandom)});
			repeat ($urandom_range(2, 1)) enc_plan.push_back({1'b0, b_lo});
		end
	endtask

	task automatic plan_button();
		int n;
		if ($urandom_range(99) < 15) begin
			repeat ($urandom_range(3, 1)) btn_plan.push_back({1'b1, 1'($urandom)});
		end else begin
			n = pick_ticks();
			repeat ($urandom_range(1)) btn_plan.push_back(2'b00);
			repeat (n) begin
				repeat ($urandom_range(1)) btn_plan.push_back(2'b00);
				btn_plan.push_back(2'b01);
			end
			btn_plan.push_back({1'b1, 1'($urandom)});
		end
	endtask

	task automatic queue_samples(input int n);
		rfp_pkg::sample_t s;
		repeat (n) begin
			if (enc_plan.size() == 0)
				plan_encoder();
			if (btn_plan.size() == 0)
				plan_button();
			if ($urandom_range(99) < 8)
				gen_playing = !gen_playing;
			{s.enc_a, s.enc_b} = enc_plan.pop_front();
			{s.button_level, s.slow_tick} = btn_plan.pop_front();
			s.radio_playing = gen_playing;
			pin_samples.push_back(s);
		end
	endtask

	task automatic write_reg(input rfp_pkg::cfg_idx_t idx, input int val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= rfp_pkg::CFG_DATA_W'(val);
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic write_panel_regs(input int hour, input int minute, input int step,
			input int short_above, input int short_below, input int long_above);
		write_reg(rfp_pkg::CFG_START_HOUR, hour);
		write_reg(rfp_pkg::CFG_START_MINUTE, minute);
		write_reg(rfp_pkg::CFG_STEP_MINUTES, step);
		write_reg(rfp_pkg::CFG_SHORT_ABOVE, short_above);
		write_reg(rfp_pkg::CFG_SHORT_BELOW, short_below);
		write_reg(rfp_pkg::CFG_LONG_ABOVE, long_above);
	endtask

	// wait until every word sent has come back, then let the pipeline settle
	task automatic drain();
		do @(posedge clk);
		while (pin_samples.size() != 0 || in_valid || due_results.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic random_regs();
		int sa;
		int sb;
		sa = $urandom_range(3);
		sb = sa + 2 + $urandom_range(3);
		write_panel_regs($urandom_range(23), $urandom_range(59), $urandom_range(30, 1),
			sa, sb, sb + $urandom_range(4));
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: day wrap both ways, equal B, station steps, press windows
		write_panel_regs(23, 58, 5, 0, 3, 1);
		pin_samples.push_back(pin(1, 0, 1, 0, 0));
		pin_samples.push_back(pin(0, 1, 1, 0, 0));
		pin_samples.push_back(pin(1, 0, 1, 0, 0));
		pin_samples.push_back(pin(0, 0, 1, 0, 0));
		pin_samples.push_back(pin(1, 1, 1, 0, 0));
		pin_samples.push_back(pin(0, 0, 1, 0, 0));
		pin_samples.push_back(pin(1, 1, 1, 0, 0));
		pin_samples.push_back(pin(0, 0, 1, 0, 1));
		pin_samples.push_back(pin(1, 0, 1, 0, 1));
		pin_samples.push_back(pin(0, 1, 1, 0, 1));
		pin_samples.push_back(pin(1, 1, 1, 0, 1));
		pin_samples.push_back(pin(1, 1, 0, 1, 1));
		pin_samples.push_back(pin(1, 1, 1, 0, 1));
		pin_samples.push_back(pin(0, 0, 0, 1, 0));
		pin_samples.push_back(pin(0, 1, 0, 1, 0));
		pin_samples.push_back(pin(1, 0, 1, 1, 0));
		pin_samples.push_back(pin(1, 0, 1, 1, 1));
		pin_samples.push_back(pin(0, 0, 0, 0, 1));
		pin_samples.push_back(pin(1, 0, 1, 0, 1));
		repeat (3) pin_samples.push_back(pin(1, 1, 0, 1, 0));
		pin_samples.push_back(pin(1, 1, 1, 0, 0));
		drain();

		random_regs();
		queue_samples(150);
		drain();

		// zero step, out of range start time, long press never reachable
		write_panel_regs(31, 63, 0, 0, 255, 255);
		queue_samples(80);
		drain();

		// widest step, short press never matches, any press with at least one tick is long
		write_panel_regs(24, 60, 31, 255, 0, 0);
		queue_samples(80);
		drain();

		// counter saturation: only a pinned count gets past the long threshold
		write_panel_regs($urandom_range(255), $urandom_range(255), 30, 254, 255, 254);
		btn_plan.delete();
		repeat (260) btn_plan.push_back(2'b01);
		btn_plan.push_back(2'b10);
		queue_samples(280);
		drain();

		random_regs();
		queue_samples(150);
		drain();

		if (n_err == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== rotary_front_panel_controller_top.f =====
rtl/core/rfp_pkg.sv
rtl/core/rfp_step.sv
rtl/core/rotary_front_panel_controller_top.sv
dv/tb.sv
